[design/pgpd_pkg.sv]
package pgpd_pkg;

    // Sample and phase formats.
    localparam int SAMPLE_WIDTH  = 16;
    localparam int PHASE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int PORT_WIDTH    = 16;
    localparam int LEN_WIDTH     = 16;

    // At most 24 rotation stages exist in the arctangent table.
    localparam int STAGE_MAX = 24;
    localparam int NSTAGES   = (CORDIC_STAGES > STAGE_MAX) ? STAGE_MAX : CORDIC_STAGES;
    localparam int ITER_W    = (NSTAGES > 1) ? $clog2(NSTAGES) : 1;

    // Datapath widths: samples are scaled by 256 and grow by the CORDIC gain.
    localparam int XY_W   = SAMPLE_WIDTH + 8 + 3;
    localparam int Z_W    = 34;
    localparam int PH_W   = PHASE_WIDTH + 1;
    localparam int DIFF_W = PHASE_WIDTH + 2;
    localparam int ATAN_W = 31;

    // Status that travels with a request from the packet tracker to the merge stage.
    typedef struct packed {
        logic first;
        logic last;
        logic coll;
    } pgpd_flags_t;

    // atan(2^-i) with 2^31 units per pi.
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 31'd536870912;
                5'd1:    v = 31'd316933406;
                5'd2:    v = 31'd167458907;
                5'd3:    v = 31'd85004756;
                5'd4:    v = 31'd42667331;
                5'd5:    v = 31'd21354465;
                5'd6:    v = 31'd10679838;
                5'd7:    v = 31'd5340245;
                5'd8:    v = 31'd2670163;
                5'd9:    v = 31'd1335087;
                5'd10:   v = 31'd667544;
                5'd11:   v = 31'd333772;
                5'd12:   v = 31'd166886;
                5'd13:   v = 31'd83443;
                5'd14:   v = 31'd41722;
                5'd15:   v = 31'd20861;
                5'd16:   v = 31'd10430;
                5'd17:   v = 31'd5215;
                5'd18:   v = 31'd2608;
                5'd19:   v = 31'd1304;
                5'd20:   v = 31'd652;
                5'd21:   v = 31'd326;
                5'd22:   v = 31'd163;
                5'd23:   v = 31'd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[design/pgpd_cordic_lane.sv]
module pgpd_cordic_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pgpd_pkg::SAMPLE_WIDTH-1:0] re,
    input  logic signed [pgpd_pkg::SAMPLE_WIDTH-1:0] im,
    output logic                                 done,
    output logic signed [pgpd_pkg::PH_W-1:0]     phase
);
    import pgpd_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_ROT  = 3'b010,
        L_RND  = 3'b100
    } lane_state_t;

    localparam logic signed [Z_W-1:0] Z_PI     = Z_W'(64'sh0000_0000_8000_0000);
    localparam logic signed [Z_W-1:0] Z_HALF_U = Z_W'(64'sd1 <<< (31 - PHASE_WIDTH));
    localparam logic signed [Z_W-1:0] P_HALF   = Z_W'(64'sd1 <<< (PHASE_WIDTH - 1));

    lane_state_t             state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    done_reg, done_next;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    zero_reg, zero_next;
    logic signed [PH_W-1:0]  phase_reg, phase_next;

    logic signed [XY_W-1:0]  x_init, y_init;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [Z_W-1:0]   atan_z;
    logic signed [Z_W-1:0]   z_rnd, p_full;

    // Scale the sample by 256; the sequencer folds the left half plane onto the right.
    always_comb
    begin
        x_init = XY_W'(re) <<< 8;
        y_init = XY_W'(im) <<< 8;
    end

    // One rotation stage, reused for every iteration.
    always_comb
    begin
        xs     = x_reg >>> iter_reg;
        ys     = y_reg >>> iter_reg;
        atan_z = Z_W'(atan_lut(5'(iter_reg)));
    end

    // Round the angle to the phase unit and clamp it to plus or minus pi.
    always_comb
    begin
        z_rnd  = z_reg + Z_HALF_U;
        p_full = z_rnd >>> (32 - PHASE_WIDTH);
        if (p_full > P_HALF)
        begin
            p_full = P_HALF;
        end
        else if (p_full < -P_HALF)
        begin
            p_full = -P_HALF;
        end
    end

    // Sequencer: load, rotate once per cycle, then round.
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    iter_next  = '0;
                    zero_next  = (re == '0) && (im == '0);
                    state_next = L_ROT;
                    if (x_init < 0)
                    begin
                        x_next = -x_init;
                        y_next = -y_init;
                        z_next = (y_init >= 0) ? Z_PI : -Z_PI;
                    end
                    else
                    begin
                        x_next = x_init;
                        y_next = y_init;
                        z_next = '0;
                    end
                end
            end
            L_ROT:
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_z;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_z;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(NSTAGES - 1))
                begin
                    state_next = L_RND;
                end
            end
            L_RND:
            begin
                phase_next = zero_reg ? '0 : PH_W'(p_full);
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        phase_reg <= phase_next;
    end

    assign done  = done_reg;
    assign phase = phase_reg;

endmodule

[design/pgpd_merge.sv]
module pgpd_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr,
    input  logic signed [pgpd_pkg::PH_W-1:0]    phase0,
    input  logic signed [pgpd_pkg::PH_W-1:0]    phase1,
    input  pgpd_pkg::pgpd_flags_t               flags,
    input  logic                                out_stall,
    output logic                                space,
    output logic                                out_valid,
    output logic signed [pgpd_pkg::PH_W-1:0]    phase_diff,
    output logic                                first_in_packet,
    output logic                                last_in_packet,
    output logic                                collision
);
    import pgpd_pkg::*;

    localparam logic signed [DIFF_W-1:0] LIM = DIFF_W'((64'sd1 <<< PHASE_WIDTH) - 64'sd1);

    logic                   valid_reg, valid_next;
    logic signed [PH_W-1:0] diff_reg;
    pgpd_flags_t            flags_reg;
    logic signed [DIFF_W-1:0] diff_full, diff_sat;

    // Difference of the two lane phases, saturated to the output range.
    always_comb
    begin
        diff_full = DIFF_W'(phase1) - DIFF_W'(phase0);
        if (diff_full > LIM)
        begin
            diff_sat = LIM;
        end
        else if (diff_full < -LIM)
        begin
            diff_sat = -LIM;
        end
        else
        begin
            diff_sat = diff_full;
        end
    end

    // The output register is free when empty or being taken this cycle.
    assign space = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            diff_reg  <= PH_W'(diff_sat);
            flags_reg <= flags;
        end
    end

    assign out_valid       = valid_reg;
    assign phase_diff      = diff_reg;
    assign first_in_packet = flags_reg.first;
    assign last_in_packet  = flags_reg.last;
    assign collision       = flags_reg.coll;

endmodule

[design/packet_gated_phase_difference_unit.sv]
// A sample inside a packet reaches the output after the lane load at the accepting edge,
// the 16 CORDIC rotations, a rounding step and the output register write, which waits
// while the output register is full and stalled. A new request is not taken until the
// previous one in a packet has written its result, held off by the iterative rotation
// stage that each antenna lane reuses for all 16 CORDIC stages; a sample outside a packet
// does not hold off the next one. Reset (rst_n, asynchronous, active low) closes any
// open packet, empties the output register and returns both lanes to idle.
module packet_gated_phase_difference_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  packet_start,
    input  logic [pgpd_pkg::LEN_WIDTH-1:0]        packet_length,
    input  logic signed [pgpd_pkg::PORT_WIDTH-1:0] ant0_real,
    input  logic signed [pgpd_pkg::PORT_WIDTH-1:0] ant0_imag,
    input  logic signed [pgpd_pkg::PORT_WIDTH-1:0] ant1_real,
    input  logic signed [pgpd_pkg::PORT_WIDTH-1:0] ant1_imag,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pgpd_pkg::PH_W-1:0]      phase_diff,
    output logic                                  first_in_packet,
    output logic                                  last_in_packet,
    output logic                                  collision
);
    import pgpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } top_state_t;

    top_state_t             state_reg, state_next;
    logic [LEN_WIDTH-1:0]   remaining_reg, remaining_next;
    pgpd_flags_t            flags_reg, flags_next;

    logic                   accept;
    logic                   rem_zero, load, hit;
    logic [LEN_WIDTH-1:0]   eff_rem;
    logic                   lane_start;
    logic                   lane0_done, lane1_done;
    logic signed [PH_W-1:0] phase0, phase1;
    logic                   space, wr;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Packet tracking: a nonzero-length tag opens a packet; inside one it is a collision.
    always_comb
    begin
        rem_zero = (remaining_reg == '0);
        load     = packet_start && rem_zero && (packet_length != '0);
        eff_rem  = load ? packet_length : remaining_reg;
        hit      = (eff_rem != '0);
    end

    assign lane_start = accept && hit;

    // Request sequencing and counter update.
    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        flags_next     = flags_reg;
        wr             = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (lane_start)
                begin
                    remaining_next   = eff_rem - 1'b1;
                    flags_next.first = load;
                    flags_next.last  = (eff_rem == LEN_WIDTH'(1));
                    flags_next.coll  = packet_start && !rem_zero;
                    state_next       = S_RUN;
                end
            end
            S_RUN:
            begin
                if (lane0_done)
                begin
                    if (space)
                    begin
                        wr         = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (space)
                begin
                    wr         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            remaining_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
    end

    // Antenna 0 lane.
    pgpd_cordic_lane u_lane0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .re    (ant0_real[SAMPLE_WIDTH-1:0]),
        .im    (ant0_imag[SAMPLE_WIDTH-1:0]),
        .done  (lane0_done),
        .phase (phase0)
    );

    // Antenna 1 lane.
    pgpd_cordic_lane u_lane1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .re    (ant1_real[SAMPLE_WIDTH-1:0]),
        .im    (ant1_imag[SAMPLE_WIDTH-1:0]),
        .done  (lane1_done),
        .phase (phase1)
    );

    // Merge the two lane phases into the output register.
    pgpd_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr              (wr),
        .phase0          (phase0),
        .phase1          (phase1),
        .flags           (flags_reg),
        .out_stall       (out_stall),
        .space           (space),
        .out_valid       (out_valid),
        .phase_diff      (phase_diff),
        .first_in_packet (first_in_packet),
        .last_in_packet  (last_in_packet),
        .collision       (collision)
    );

    // Both lanes run in lockstep and must finish together.
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lane0_done == lane1_done)
        else $error("antenna lanes finished out of step");

    // A lane only finishes while a request is being processed.
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        lane0_done |-> (state_reg == S_RUN))
        else $error("lane finished with no request in flight");

    // A new result appears only after a request was in flight.
    a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RUN || state_reg == S_HOLD))
        else $error("result appeared without a request");

    // The last sample of a packet closes it.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_start && (eff_rem == LEN_WIDTH'(1))) |=> (remaining_reg == '0))
        else $error("packet left open after its last sample");

endmodule

[test/packet_gated_phase_difference_unit_tb.sv]
`timescale 1ns / 100ps

module packet_gated_phase_difference_unit_tb;

    localparam int SW      = pgpd_pkg::SAMPLE_WIDTH;
    localparam int PW      = pgpd_pkg::PHASE_WIDTH;
    localparam int PH_W    = pgpd_pkg::PH_W;
    localparam int LEN_W   = pgpd_pkg::LEN_WIDTH;
    localparam int PORT_W  = pgpd_pkg::PORT_WIDTH;
    localparam int N_ROT   = (pgpd_pkg::CORDIC_STAGES > 24) ? 24 : pgpd_pkg::CORDIC_STAGES;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    // Rotation angles atan(2^-i), 2^31 units per pi.
    localparam longint ROT_ANGLE [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic                     start;
        logic [LEN_W-1:0]         len;
        logic signed [PORT_W-1:0] a0_re;
        logic signed [PORT_W-1:0] a0_im;
        logic signed [PORT_W-1:0] a1_re;
        logic signed [PORT_W-1:0] a1_im;
    } sample_t;

    typedef struct {
        logic signed [PH_W-1:0] diff;
        logic                   first;
        logic                   last;
        logic                   coll;
    } phase_result_t;

    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_NONE,
        CHECK_TYPED
    } row_check_t;

    typedef struct {
        sample_t       s;
        row_check_t    check;
        phase_result_t res;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     packet_start;
    logic [LEN_W-1:0]         packet_length;
    logic signed [PORT_W-1:0] ant0_real;
    logic signed [PORT_W-1:0] ant0_imag;
    logic signed [PORT_W-1:0] ant1_real;
    logic signed [PORT_W-1:0] ant1_imag;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [PH_W-1:0]   phase_diff;
    logic                     first_in_packet;
    logic                     last_in_packet;
    logic                     collision;

    phase_result_t phase_results_due[$];
    stim_row_t     directed_rows[$];
    logic [LEN_W-1:0] samples_left;
    int  results_due_total;
    int  mismatch_count;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_request;

    packet_gated_phase_difference_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_start    (packet_start),
        .packet_length   (packet_length),
        .ant0_real       (ant0_real),
        .ant0_imag       (ant0_imag),
        .ant1_real       (ant1_real),
        .ant1_imag       (ant1_imag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase_diff      (phase_diff),
        .first_in_packet (first_in_packet),
        .last_in_packet  (last_in_packet),
        .collision       (collision)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count and print one line per mismatch.
    task automatic flag_mismatch(input string what);
        begin
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Take the low sample bits and sign-extend them.
    function automatic longint sample_value(input logic [PORT_W-1:0] raw);
        longint v;
        begin
            v = longint'(raw);
            return (v <<< (64 - SW)) >>> (64 - SW);
        end
    endfunction

    // Vectoring CORDIC angle of one antenna sample, in phase units.
    function automatic longint antenna_phase(input longint re, input longint im);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint p;
        longint half;
        int     i;
        begin
            x = re * 256;
            y = im * 256;
            z = 0;
            half = longint'(1) <<< (PW - 1);
            if (re == 0 && im == 0)
            begin
                return 0;
            end
            // Left half plane: turn by pi first.
            if (x < 0)
            begin
                z = (y >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
                x = -x;
                y = -y;
            end
            for (i = 0; i < N_ROT; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ROT_ANGLE[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ROT_ANGLE[i];
                end
            end
            p = (z + (longint'(1) <<< (31 - PW))) >>> (32 - PW);
            if (p > half)
            begin
                p = half;
            end
            if (p < -half)
            begin
                p = -half;
            end
            return p;
        end
    endfunction

    // Packet tracking and phase difference for one accepted sample.
    // Returns 1 when the sample produces a result.
    function automatic bit track_packet_phase(input sample_t s, output phase_result_t r);
        longint d;
        longint lim;
        bit     first;
        bit     coll;
        begin
            first = 1'b0;
            coll = 1'b0;
            lim = (longint'(1) <<< PW) - 1;
            if (s.start)
            begin
                if (samples_left != 0)
                begin
                    coll = 1'b1;
                end
                else if (s.len != 0)
                begin
                    samples_left = s.len;
                    first = 1'b1;
                end
            end
            if (samples_left == 0)
            begin
                return 1'b0;
            end
            r.last = (samples_left == 1);
            samples_left = samples_left - 1'b1;
            d = antenna_phase(sample_value(s.a1_re), sample_value(s.a1_im))
                - antenna_phase(sample_value(s.a0_re), sample_value(s.a0_im));
            if (d > lim)
            begin
                d = lim;
            end
            if (d < -lim)
            begin
                d = -lim;
            end
            r.diff = d[PH_W-1:0];
            r.first = first;
            r.coll = coll;
            return 1'b1;
        end
    endfunction

    // Drive one request at the falling edge and wait until it is taken.
    task automatic offer_sample(input sample_t s);
        begin
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid      <= 1'b1;
            packet_start  <= s.start;
            packet_length <= s.len;
            ant0_real     <= s.a0_re;
            ant0_imag     <= s.a0_im;
            ant1_real     <= s.a1_re;
            ant1_imag     <= s.a1_im;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
        end
    endtask

    // Send a request and queue whatever result it should produce.
    task automatic send_sample(input sample_t s);
        phase_result_t r;
        begin
            offer_sample(s);
            if (track_packet_phase(s, r))
            begin
                phase_results_due.push_back(r);
                results_due_total++;
            end
        end
    endtask

    // Sample components weighted toward the extremes of the range.
    function automatic logic signed [PORT_W-1:0] random_component();
        begin
            case ($urandom_range(9))
                0: return PORT_W'(-32768);
                1: return PORT_W'(32767);
                2: return '0;
                3: return PORT_W'($signed($urandom_range(16)) - 8);
                default: return PORT_W'($urandom);
            endcase
        end
    endfunction

    function automatic sample_t random_sample(input logic start, input logic [LEN_W-1:0] len);
        sample_t s;
        begin
            s.start = start;
            s.len = len;
            s.a0_re = random_component();
            s.a0_im = random_component();
            s.a1_re = random_component();
            s.a1_im = random_component();
            return s;
        end
    endfunction

    // A few stray samples, then a tagged packet with random content.
    // A length of zero asks for a random length.
    task automatic send_packet(input int len_req);
        int len;
        int pick;
        int k;
        begin
            repeat ($urandom_range(2))
            begin
                if ($urandom_range(5) == 0)
                begin
                    send_sample(random_sample(1'b1, '0));
                end
                else
                begin
                    send_sample(random_sample(1'b0, LEN_W'($urandom)));
                end
            end
            len = len_req;
            if (len == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    len = $urandom_range(6, 1);
                end
                else if (pick < 97)
                begin
                    len = $urandom_range(24, 7);
                end
                else
                begin
                    len = $urandom_range(40, 25);
                end
            end
            send_sample(random_sample(1'b1, LEN_W'(len)));
            // Stray tags inside the packet show up as collisions.
            for (k = 1; k < len; k++)
            begin
                send_sample(random_sample($urandom_range(9) == 0, LEN_W'($urandom)));
            end
        end
    endtask

    task automatic add_row(input logic start, input logic [LEN_W-1:0] len,
                           input logic signed [PORT_W-1:0] a0r,
                           input logic signed [PORT_W-1:0] a0i,
                           input logic signed [PORT_W-1:0] a1r,
                           input logic signed [PORT_W-1:0] a1i,
                           input row_check_t check, input logic signed [PH_W-1:0] diff,
                           input logic first, input logic last, input logic coll);
        stim_row_t row;
        begin
            row.s.start = start;
            row.s.len = len;
            row.s.a0_re = a0r;
            row.s.a0_im = a0i;
            row.s.a1_re = a1r;
            row.s.a1_im = a1i;
            row.check = check;
            row.res.diff = diff;
            row.res.first = first;
            row.res.last = last;
            row.res.coll = coll;
            directed_rows.push_back(row);
        end
    endtask

    // Receiver: random stalls, or one long hold when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Compare every accepted result with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        phase_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (phase_results_due.size() == 0)
            begin
                flag_mismatch($sformatf("result diff=%0d with none expected", phase_diff));
            end
            else
            begin
                want = phase_results_due.pop_front();
                if (phase_diff !== want.diff || first_in_packet !== want.first
                    || last_in_packet !== want.last || collision !== want.coll)
                begin
                    flag_mismatch($sformatf(
                        "got diff=%0d first=%b last=%b coll=%b, want %0d %b %b %b",
                        phase_diff, first_in_packet, last_in_packet, collision,
                        want.diff, want.first, want.last, want.coll));
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        phase_result_t r;
        stim_row_t     row;
        int            ph;
        int            target;
        int            drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        packet_start = 1'b0;
        packet_length = '0;
        ant0_real = '0;
        ant0_imag = '0;
        ant1_real = '0;
        ant1_imag = '0;
        samples_left = '0;
        results_due_total = 0;
        mismatch_count = 0;
        hold_request = 1'b0;
        tx_idle_pct = 20;
        rx_idle_pct = 73;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: outside a packet, zero-length tag, zero vectors, extremes,
        // collisions, every quadrant and the axes.
        add_row(0, 16'h0000, 100, 200, 300, 400, CHECK_NONE, 0, 0, 0, 0);
        add_row(1, 16'h0000, 1, 2, 3, 4, CHECK_NONE, 0, 0, 0, 0);
        add_row(1, 16'h0003, 0, 0, 0, 0, CHECK_TYPED, 0, 1, 0, 0);
        add_row(0, 16'h0000, -32768, -32768, -32768, -32768, CHECK_TYPED, 0, 0, 0, 0);
        add_row(1, 16'hFFFF, 32767, 32767, 32767, 32767, CHECK_TYPED, 0, 0, 1, 1);
        add_row(1, 16'h0001, -32768, -1, -32768, 0, CHECK_MODEL, 0, 0, 0, 0);
        add_row(1, 16'h0002, -32768, 0, -32768, -1, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'h0000, 0, -32768, 0, 32767, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'hAAAA, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
                CHECK_NONE, 0, 0, 0, 0);
        add_row(0, 16'h5555, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA,
                CHECK_NONE, 0, 0, 0, 0);
        add_row(1, 16'h0004, 32767, 0, 0, 32767, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'h0000, -1, -1, 1, 1, CHECK_MODEL, 0, 0, 0, 0);
        add_row(1, 16'h5555, -32768, 32767, 32767, -32768, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'h0000, -32768, 0, -32768, -32768, CHECK_MODEL, 0, 0, 0, 0);
        add_row(1, 16'h0001, 1234, -5678, 1234, -5678, CHECK_TYPED, 0, 1, 1, 0);
        add_row(1, 16'h0002, 0, 0, 5, 0, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'h0000, 0, -7, 0, 0, CHECK_MODEL, 0, 0, 0, 0);
        add_row(0, 16'h7FFF, 32767, -32768, 32767, -32768, CHECK_NONE, 0, 0, 0, 0);
        add_row(1, 16'h0001, 1, 0, -1, 0, CHECK_MODEL, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            offer_sample(row.s);
            if (track_packet_phase(row.s, r) && row.check == CHECK_MODEL)
            begin
                phase_results_due.push_back(r);
            end
            if (row.check == CHECK_TYPED)
            begin
                phase_results_due.push_back(row.res);
            end
        end

        // Random packets under three idling patterns.
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 73;
                end
                1:
                begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 20;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // Long receiver hold while a full packet keeps coming in.
            if (ph == 2)
            begin
                hold_request = 1'b1;
                send_packet(24);
            end
            target = results_due_total + 115;
            while (results_due_total < target)
            begin
                send_packet(0);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle.
        drain = 0;
        while (phase_results_due.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (phase_results_due.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    phase_results_due.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
